// File: rtl/escu8_pkg.sv
// ----------------------------------------------------------------------------
// escu8_pkg: shared types and constants of the escaped-string UTF-8 decoder
// Parse modes, decoded record layout and the character codes of the escapes.
// ----------------------------------------------------------------------------
package escu8_pkg;

	// parse mode of the front end
	typedef enum logic [2:0] {
		MODE_TEXT = 3'd0,
		MODE_ESC  = 3'd1,
		MODE_HEX0 = 3'd2,
		MODE_HEX1 = 3'd3,
		MODE_HEX2 = 3'd4,
		MODE_HEX3 = 3'd5
	} mode_t;

	// what one accepted word turns into before encoding
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_UNIT = 2'd2
	} kind_t;

	// one decoded record: 1 to 4 output bytes caused by one input word
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            bvalid;
		logic            last;
	} rec_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] BYTE_LF   = 8'h0A;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] BYTE_TAB  = 8'h09;

	localparam logic [16:0] UNIT_ONE_MAX   = 17'h0007F;
	localparam logic [16:0] UNIT_TWO_MAX   = 17'h007FF;
	localparam logic [16:0] UNIT_THREE_MAX = 17'h0D7FF;
	localparam logic [16:0] UNIT_HIGH_MAX  = 17'h0DBFF;
	localparam logic [16:0] UNIT_LOW_MAX   = 17'h0DFFF;
	localparam logic [16:0] UNIT_BMP_MAX   = 17'h0FFFF;
	localparam logic [31:0] SURR_HIGH_BASE = 32'h0000D800;
	localparam logic [31:0] SURR_LOW_BASE  = 32'h0000DC00;
	localparam logic [31:0] SUPP_BASE      = 32'h00010000;

endpackage

// File: rtl/escu8_front.sv
// ----------------------------------------------------------------------------
// escu8_front: escape parser and UTF-8 encoder
// Takes one source byte a cycle unless the queue is full; tracks the escape
// state, registers the classified word and encodes a record of up to 4 bytes.
// ----------------------------------------------------------------------------
module escu8_front import escu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output rec_t       push_rec,
	input  logic       full
);

	mode_t       mode_q, mode_next;
	logic [16:0] acc_q;
	logic [16:0] acc_next;
	logic [4:0]  digit;
	kind_t       kind_c;
	logic [7:0]  byte_c;
	logic        accept;

	logic        valid_s1;
	kind_t       kind_s1;
	logic [7:0]  byte_s1;
	logic [16:0] unit_s1;
	logic        last_s1;

	logic [15:0] hs_q;
	logic [20:0] cp;
	rec_t        rec_c;
	logic        store_high;
	logic        consume;

	// hex digit value and accumulator step
	assign digit    = {1'b0, in_byte[3:0]} + ((in_byte > CH_NINE) ? 5'd9 : 5'd0);
	assign acc_next = 17'({acc_q, 4'b0} + {12'b0, digit});

	assign consume  = valid_s1 && (!push || !full);
	assign in_ready = !valid_s1 || consume;
	assign accept   = in_valid && in_ready;

	// next parse mode
	always_comb begin
		mode_next = mode_q;
		unique case (mode_q)
			MODE_TEXT: mode_next = (in_byte == CH_BSLASH) ? MODE_ESC : MODE_TEXT;
			MODE_ESC:  mode_next = (in_byte == CH_U) ? MODE_HEX0 : MODE_TEXT;
			MODE_HEX0: mode_next = MODE_HEX1;
			MODE_HEX1: mode_next = MODE_HEX2;
			MODE_HEX2: mode_next = MODE_HEX3;
			MODE_HEX3: mode_next = MODE_TEXT;
			default:   mode_next = MODE_TEXT;
		endcase
		if (in_last) begin
			mode_next = MODE_TEXT;
		end
	end

	// classify the word for the encoder
	always_comb begin
		kind_c = KIND_NONE;
		byte_c = in_byte;
		unique case (mode_q)
			MODE_TEXT: begin
				kind_c = (in_byte == CH_BSLASH) ? KIND_NONE : KIND_BYTE;
			end
			MODE_ESC: begin
				kind_c = KIND_BYTE;
				unique case (in_byte)
					CH_N:    byte_c = BYTE_LF;
					CH_R:    byte_c = BYTE_CR;
					CH_T:    byte_c = BYTE_TAB;
					CH_U:    kind_c = KIND_NONE;
					default: byte_c = in_byte;
				endcase
			end
			MODE_HEX0, MODE_HEX1, MODE_HEX2: kind_c = KIND_NONE;
			MODE_HEX3: kind_c = KIND_UNIT;
			default:   kind_c = KIND_BYTE;
		endcase
	end

	// advance parse state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			acc_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_next;
			if (in_last || (mode_q == MODE_ESC && in_byte == CH_U)) begin
				acc_q <= '0;
			end else if (mode_q == MODE_HEX0 || mode_q == MODE_HEX1 ||
			             mode_q == MODE_HEX2 || mode_q == MODE_HEX3) begin
				acc_q <= acc_next;
			end
		end
	end

	// hold the classified word in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_c;
			byte_s1 <= byte_c;
			unit_s1 <= acc_next;
			last_s1 <= in_last;
		end
	end

	// supplementary point from the held high surrogate, 21 bits kept
	assign cp = 21'(SUPP_BASE + ((32'(hs_q) - SURR_HIGH_BASE) << 10)
	                + (32'(unit_s1) - SURR_LOW_BASE));

	// encode stage 1 into a record
	always_comb begin
		rec_c        = '0;
		rec_c.bvalid = 1'b1;
		rec_c.last   = last_s1;
		store_high   = 1'b0;
		case (kind_s1)
			KIND_BYTE: begin
				rec_c.cnt      = 3'd1;
				rec_c.bytes[0] = byte_s1;
			end
			KIND_UNIT: begin
				if (unit_s1 <= UNIT_ONE_MAX) begin
					rec_c.cnt      = 3'd1;
					rec_c.bytes[0] = unit_s1[7:0];
				end else if (unit_s1 <= UNIT_TWO_MAX) begin
					rec_c.cnt      = 3'd2;
					rec_c.bytes[0] = {3'b110, unit_s1[10:6]};
					rec_c.bytes[1] = {2'b10, unit_s1[5:0]};
				end else if (unit_s1 <= UNIT_THREE_MAX ||
				             (unit_s1 > UNIT_LOW_MAX && unit_s1 <= UNIT_BMP_MAX)) begin
					rec_c.cnt      = 3'd3;
					rec_c.bytes[0] = {4'b1110, unit_s1[15:12]};
					rec_c.bytes[1] = {2'b10, unit_s1[11:6]};
					rec_c.bytes[2] = {2'b10, unit_s1[5:0]};
				end else if (unit_s1 <= UNIT_HIGH_MAX) begin
					store_high = 1'b1;
				end else if (unit_s1 <= UNIT_LOW_MAX) begin
					rec_c.cnt      = 3'd4;
					rec_c.bytes[0] = {5'b11110, cp[20:18]};
					rec_c.bytes[1] = {2'b10, cp[17:12]};
					rec_c.bytes[2] = {2'b10, cp[11:6]};
					rec_c.bytes[3] = {2'b10, cp[5:0]};
				end
			end
			default: rec_c.cnt = 3'd0;
		endcase
		// end-only marker when the final word yields nothing
		if (last_s1 && rec_c.cnt == 3'd0) begin
			rec_c.cnt    = 3'd1;
			rec_c.bvalid = 1'b0;
		end
	end

	assign push     = valid_s1 && (rec_c.cnt != 3'd0);
	assign push_rec = rec_c;

	// hold the high surrogate until the string ends or another replaces it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
		end else if (consume) begin
			if (last_s1) begin
				hs_q <= '0;
			end else if (store_high) begin
				hs_q <= unit_s1[15:0];
			end
		end
	end

endmodule

// File: rtl/escu8_queue.sv
// ----------------------------------------------------------------------------
// escu8_queue: record queue between parser and serializer
// Small circular buffer of decoded records with full and empty flags.
// ----------------------------------------------------------------------------
module escu8_queue import escu8_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t head,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// store incoming record
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/escu8_back.sv
// ----------------------------------------------------------------------------
// escu8_back: output serializer
// Walks head record bytes to an output register one per cycle unless stalled.
// ----------------------------------------------------------------------------
module escu8_back import escu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rec_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_bvalid,
	output logic       out_run_last,
	output logic       out_end
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q, run_last_q, end_q;

	assign load   = !valid_q || out_ready;
	assign at_end = ({1'b0, idx_q} == 3'(head.cnt - 3'd1));
	assign pop    = load && !empty && at_end;

	// advance byte index within the head record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// load the output word
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			byte_q     <= head.bytes[idx_q];
			bvalid_q   <= head.bvalid;
			run_last_q <= at_end;
			end_q      <= at_end && head.last;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign out_bvalid   = bvalid_q;
	assign out_run_last = run_last_q;
	assign out_end      = end_q;

endmodule

// File: rtl/escape_unicode_to_utf8_decoder.sv
// ----------------------------------------------------------------------------
// escape_unicode_to_utf8_decoder: escaped string to UTF-8 byte stream
// Throughput: one input byte and one output word per cycle unless back-pressure
// stalls; one byte a cycle at the serializer bounds it when escapes expand.
// Reset: arst_n clears parse state, held surrogate, queue and output valid.
// ----------------------------------------------------------------------------
module escape_unicode_to_utf8_decoder import escu8_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // string_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] run_last
	output logic       m_tlast    // output_end
);

	logic push, full, pop, empty;
	rec_t push_rec, head;

	escu8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.push_rec (push_rec),
		.full     (full)
	);

	escu8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	escu8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.out_bvalid   (m_tuser[0]),
		.out_run_last (m_tuser[1]),
		.out_end      (m_tlast)
	);

endmodule
